FILE: hw/rtl/tvfd_pkg.sv
`timescale 1ns / 1ps
// Package for the typed varint field decoder.
// Holds payload structs, field kinds, result roles and decoder state types.
package tvfd_pkg;

  typedef enum logic [3:0] {
    KIND_OCTET  = 4'd0,
    KIND_BOOL   = 4'd1,
    KIND_USHORT = 4'd2,
    KIND_SHORT  = 4'd3,
    KIND_UINT   = 4'd4,
    KIND_INT    = 4'd5,
    KIND_ULONG  = 4'd6,
    KIND_LONG   = 4'd7,
    KIND_STRING = 4'd8,
    KIND_TAG    = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_SCALAR  = 2'd0,
    ROLE_LENGTH  = 2'd1,
    ROLE_PAYLOAD = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_SCALAR  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  localparam logic [7:0] ContMask  = 8'h80;
  localparam logic [6:0] VarShiftEnd = 7'd64;
  localparam logic [6:0] VarShiftStep = 7'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] field_kind;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  value_kind;
    logic [1:0]  role;
    logic        field_end;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] accumulator;
    logic [6:0]  bit_shift;
    logic [3:0]  byte_count;
    logic [3:0]  current_kind;
    logic [31:0] payload_remaining;
  } dec_state_t;

endpackage

FILE: hw/rtl/tvfd_step.sv
`timescale 1ns / 1ps
// Next-state and result logic of the decoder for one incoming byte.
// Depends on tvfd_pkg for the state, item and kind types.
module tvfd_step import tvfd_pkg::*; (
  input  dec_state_t state_i,
  input  logic       varint_en_i,
  input  in_item_t   item_i,
  output dec_state_t state_o,
  output logic       res_valid_o,
  output out_item_t  res_o
);

  logic        start;
  logic [3:0]  kind;
  logic [63:0] acc;
  logic [6:0]  shift;
  logic [3:0]  count;
  logic [7:0]  b;
  logic [63:0] acc_var;
  logic [63:0] acc_fix;
  logic [3:0]  count_inc;
  logic [3:0]  need;
  logic [63:0] raw;
  logic [31:0] z32;
  logic [63:0] z64;
  logic [31:0] rem_dec;
  logic        done;

  assign b         = item_i.data_byte;
  assign start     = (state_i.phase == PH_IDLE);
  assign kind      = start ? item_i.field_kind : state_i.current_kind;
  assign acc       = start ? 64'd0 : state_i.accumulator;
  assign shift     = start ? 7'd0 : state_i.bit_shift;
  assign count     = start ? 4'd0 : state_i.byte_count;
  assign acc_var   = shift[6] ? acc : (acc | ({57'd0, b[6:0]} << shift[5:0]));
  assign acc_fix   = {acc[55:0], b};
  assign count_inc = count + 4'd1;
  assign raw       = varint_en_i ? acc_var : acc_fix;
  assign z32       = varint_en_i ? ({1'b0, raw[31:1]} ^ {32{raw[0]}}) : raw[31:0];
  assign z64       = varint_en_i ? ({1'b0, raw[63:1]} ^ {64{raw[0]}}) : raw;
  assign rem_dec   = state_i.payload_remaining - 32'd1;

  always_comb begin
    case (kind_e'(kind))
      KIND_USHORT, KIND_SHORT: need = 4'd2;
      KIND_ULONG, KIND_LONG:   need = 4'd8;
      default:                 need = 4'd4;
    endcase
    done = varint_en_i ? ((b & ContMask) == 8'd0) : (count_inc >= need);
  end

  always_comb begin
    state_o             = state_i;
    res_valid_o         = 1'b0;
    res_o.value         = {56'd0, b};
    res_o.value_kind    = kind;
    res_o.role          = ROLE_SCALAR;
    res_o.field_end     = 1'b1;
    if (state_i.phase == PH_PAYLOAD) begin
      state_o.payload_remaining = rem_dec;
      res_valid_o               = 1'b1;
      res_o.role                = ROLE_PAYLOAD;
      res_o.field_end           = (rem_dec == 32'd0);
      if (rem_dec == 32'd0) begin
        state_o.phase = PH_IDLE;
      end
    end else if (!(start && (item_i.field_kind > KIND_TAG))) begin
      state_o.current_kind = kind;
      state_o.phase        = PH_SCALAR;
      state_o.accumulator  = raw;
      state_o.bit_shift    = shift;
      state_o.byte_count   = count;
      if (varint_en_i) begin
        if (!shift[6] && !done) begin
          state_o.bit_shift = shift + VarShiftStep;
        end
      end else begin
        state_o.byte_count = count_inc;
      end
      case (kind_e'(kind))
        KIND_OCTET: begin
          state_o.phase = PH_IDLE;
          res_valid_o   = 1'b1;
          res_o.value   = {{56{b[7]}}, b};
        end
        KIND_BOOL: begin
          state_o.phase = PH_IDLE;
          res_valid_o   = 1'b1;
          res_o.value   = {63'd0, (b == 8'd1)};
        end
        default: begin
          if (done) begin
            state_o.phase = PH_IDLE;
            res_valid_o   = 1'b1;
            case (kind_e'(kind))
              KIND_USHORT: res_o.value = {48'd0, raw[15:0]};
              KIND_SHORT:  res_o.value = {{48{z32[15]}}, z32[15:0]};
              KIND_UINT:   res_o.value = {32'd0, raw[31:0]};
              KIND_INT:    res_o.value = {{32{z32[31]}}, z32};
              KIND_ULONG:  res_o.value = raw;
              KIND_LONG:   res_o.value = z64;
              KIND_TAG:    res_o.value = {56'd0, z32[7:0]};
              default: begin
                state_o.payload_remaining = raw[31:0];
                res_o.value               = {32'd0, raw[31:0]};
                res_o.role                = ROLE_LENGTH;
                res_o.field_end           = (raw[31:0] == 32'd0);
                if (raw[31:0] != 32'd0) begin
                  state_o.phase = PH_PAYLOAD;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/typed_varint_field_decoder_top.sv
`timescale 1ns / 1ps
// Typed varint field decoder, top level: one byte per transaction.
// Results are registered: a result is valid in the cycle after its byte's transaction.
// Throughput: one byte per cycle while results are taken; the result register frees as it is taken.
// Reset: decoder idle, result register empty, varint_enable set to 1.
// Depends on tvfd_pkg and tvfd_step.
module typed_varint_field_decoder_top import tvfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dec_state_t state_q, state_d;
  logic       varint_en_q;
  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       res_valid;
  out_item_t  res;
  logic       in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tvfd_step u_step (
    .state_i     (state_q),
    .varint_en_i (varint_en_q),
    .item_i      (in_data_i),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      varint_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      varint_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_data_q <= res;
    end
  end

endmodule

FILE: hw/rtl/tvfd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the typed varint field decoder, bound to the top.
// Depends on tvfd_pkg for roles and the payload structs.
module tvfd_checker import tvfd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with result register free");

  a_role_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.role == ROLE_SCALAR || out_data_o.role == ROLE_LENGTH ||
                     out_data_o.role == ROLE_PAYLOAD))
    else $error("illegal result role");

  a_scalar_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.role == ROLE_SCALAR |-> out_data_o.field_end)
    else $error("scalar result not marked as field end");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.role == ROLE_LENGTH && out_data_o.value == 64'd0
    |-> out_data_o.field_end)
    else $error("empty string length not marked as field end");

endmodule

bind typed_varint_field_decoder_top tvfd_checker u_tvfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/typed_varint_field_decoder_top_tb.sv
`timescale 1ns / 1ps
// Testbench for typed_varint_field_decoder_top: directed and random byte streams in both
// coding modes, checked against a decoder model kept in a small scoreboard class.
// Depends on tvfd_pkg and the decoder RTL.
module typed_varint_field_decoder_top_tb;
  import tvfd_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned ItemTarget = 1650;

  class decode_scoreboard;
    bit          varint_en;
    phase_e      ph;
    logic [63:0] acc;
    logic [6:0]  shift;
    logic [3:0]  count;
    kind_e       kind;
    logic [31:0] remaining;
    out_item_t   decoded_q[$];
    int unsigned errors;

    function new();
      varint_en = 1'b1;
      ph = PH_IDLE;
      acc = '0;
      shift = '0;
      count = '0;
      kind = KIND_OCTET;
      remaining = '0;
      errors = 0;
    endfunction

    function logic [63:0] unzigzag32(logic [63:0] raw);
      logic [31:0] u;
      u = {1'b0, raw[31:1]} ^ {32{raw[0]}};
      return {32'b0, u};
    endfunction

    function void add_decoded(logic [63:0] v, role_e role, bit last);
      out_item_t r;
      r.value = v;
      r.value_kind = kind;
      r.role = role;
      r.field_end = last;
      decoded_q.push_back(r);
    endfunction

    function void complete_scalar(logic [63:0] raw, bit vm);
      logic [63:0] v;
      ph = PH_IDLE;
      case (kind)
        KIND_USHORT: v = {48'b0, raw[15:0]};
        KIND_SHORT: begin
          v = vm ? unzigzag32(raw) : raw;
          v = {{48{v[15]}}, v[15:0]};
        end
        KIND_UINT: v = {32'b0, raw[31:0]};
        KIND_INT: begin
          v = vm ? unzigzag32(raw) : raw;
          v = {{32{v[31]}}, v[31:0]};
        end
        KIND_ULONG: v = raw;
        KIND_LONG: v = vm ? ({1'b0, raw[63:1]} ^ {64{raw[0]}}) : raw;
        KIND_TAG: begin
          v = vm ? unzigzag32(raw) : raw;
          v = {56'b0, v[7:0]};
        end
        default: begin
          remaining = raw[31:0];
          if (remaining != 0) ph = PH_PAYLOAD;
          add_decoded({32'b0, remaining}, ROLE_LENGTH, remaining == 0);
          return;
        end
      endcase
      add_decoded(v, ROLE_SCALAR, 1'b1);
    endfunction

    // Return 0 when the byte is dropped as an undefined field start.
    function bit decode_byte(in_item_t it);
      logic [7:0]  b;
      int unsigned need;
      b = it.data_byte;
      if (ph == PH_PAYLOAD) begin
        remaining = remaining - 32'd1;
        if (remaining == 0) ph = PH_IDLE;
        add_decoded({56'b0, b}, ROLE_PAYLOAD, remaining == 0);
        return 1'b1;
      end
      if (ph != PH_SCALAR) begin
        if (it.field_kind > KIND_TAG) return 1'b0;
        kind = kind_e'(it.field_kind);
        acc = '0;
        shift = '0;
        count = '0;
        ph = PH_SCALAR;
      end
      if (kind == KIND_OCTET) begin
        ph = PH_IDLE;
        add_decoded({{56{b[7]}}, b}, ROLE_SCALAR, 1'b1);
        return 1'b1;
      end
      if (kind == KIND_BOOL) begin
        ph = PH_IDLE;
        add_decoded((b == 8'd1) ? 64'd1 : 64'd0, ROLE_SCALAR, 1'b1);
        return 1'b1;
      end
      if (varint_en) begin
        if (shift < VarShiftEnd) acc = acc | (64'(b[6:0]) << shift);
        if ((b & ContMask) != 0) begin
          if (shift < VarShiftEnd) shift = shift + VarShiftStep;
          return 1'b1;
        end
        complete_scalar(acc, 1'b1);
        return 1'b1;
      end
      acc = {acc[55:0], b};
      count = count + 4'd1;
      case (kind)
        KIND_USHORT, KIND_SHORT: need = 2;
        KIND_ULONG, KIND_LONG:   need = 8;
        default:                 need = 4;
      endcase
      if (count >= need) complete_scalar(acc, 1'b0);
      return 1'b1;
    endfunction

    function void check_decoded(out_item_t got);
      out_item_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: value %h kind %0d role %0d", got.value, got.value_kind,
               got.role);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %h, actual %h", want.value, got.value);
        errors++;
      end
      if (got.value_kind !== want.value_kind) begin
        $error("value_kind: expected %0d, actual %0d", want.value_kind, got.value_kind);
        errors++;
      end
      if (got.role !== want.role) begin
        $error("role: expected %0d, actual %0d", want.role, got.role);
        errors++;
      end
      if (got.field_end !== want.field_end) begin
        $error("field_end: expected %0d, actual %0d", want.field_end, got.field_end);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  decode_scoreboard sb;
  int unsigned      items_used;
  int unsigned      idle_cycles;
  bit               hold_req;
  bit               tx_gaps;
  bit               rx_gaps;

  typed_varint_field_decoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [3:0] any_kind();
    return 4'($urandom);
  endfunction

  task automatic send_byte(logic [3:0] k, logic [7:0] b);
    in_item_t    it;
    int unsigned gap;
    it.data_byte = b;
    it.field_kind = k;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.decode_byte(it)) items_used++;
  endtask

  // First byte carries the kind; later bytes carry random kinds.
  task automatic send_bytes(logic [3:0] k, int unsigned n, logic [127:0] v);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte((i == 0) ? k : any_kind(), v[8*(n-1-i) +: 8]);
    end
  endtask

  task automatic finish_field();
    while (sb.ph != PH_IDLE) send_byte(any_kind(), 8'h00);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_varint_enable(bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.varint_en = v;
  endtask

  task automatic send_random_field();
    kind_e       k;
    int unsigned n;
    int unsigned len;
    int unsigned r;
    bit          full;
    logic [7:0]  b;
    if ($urandom_range(0, 11) == 0) begin
      send_byte(4'($urandom_range(10, 15)), 8'($urandom));
      return;
    end
    k = kind_e'($urandom_range(0, 9));
    full = ($urandom_range(0, 7) == 0);
    case (k)
      KIND_OCTET, KIND_BOOL: begin
        b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        send_byte(k, b);
      end
      KIND_STRING: begin
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        if (!sb.varint_en) begin
          send_bytes(k, 4, 128'(len));
        end else if ($urandom_range(0, 3) == 0) begin
          send_byte(k, 8'(len) | ContMask);
          send_byte(any_kind(), ContMask);
          send_byte(any_kind(), 8'h00);
        end else begin
          send_byte(k, 8'(len));
        end
        repeat (len) send_byte(any_kind(), 8'($urandom));
      end
      default: begin
        if (sb.varint_en) begin
          r = $urandom_range(0, 19);
          n = (r < 8) ? $urandom_range(1, 3) : (r < 17) ? $urandom_range(4, 10) :
              $urandom_range(11, 13);
        end else begin
          case (k)
            KIND_USHORT, KIND_SHORT: n = 2;
            KIND_ULONG, KIND_LONG:   n = 8;
            default:                 n = 4;
          endcase
        end
        for (int unsigned i = 0; i < n; i++) begin
          b = full ? 8'hFF : 8'($urandom);
          if (sb.varint_en) b[7] = (i != n - 1);
          send_byte((i == 0) ? k : any_kind(), b);
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_decoded(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (taken % 64 == 0) rx_gaps = $urandom_range(0, 1);
      taken++;
      stall = rx_gaps ? $urandom_range(0, 5) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned target;
    int unsigned phase_no;
    sb = new();
    items_used = 0;
    phase_no = 0;
    hold_req = 1'b0;
    tx_gaps = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_varint_enable(1'b1);
    send_bytes(KIND_OCTET, 1, 128'h80);
    send_bytes(KIND_BOOL, 1, 128'h01);
    send_bytes(KIND_BOOL, 1, 128'h02);
    send_bytes(KIND_USHORT, 3, 128'hFFFF03);
    send_bytes(KIND_SHORT, 1, 128'h01);
    send_bytes(KIND_INT, 5, 128'hFF_FFFF_FF0F);
    send_bytes(KIND_ULONG, 10, 128'hFFFF_FFFF_FFFF_FFFF_FF01);
    send_bytes(KIND_LONG, 12, 128'hFFFF_FFFF_FFFF_FFFF_FFFF_FF7F);
    send_bytes(KIND_TAG, 2, 128'hAC02);
    send_bytes(KIND_STRING, 1, 128'h00);
    send_bytes(KIND_STRING, 1, 128'h02);
    send_bytes(any_kind(), 2, 128'hFF00);
    send_byte(4'hF, 8'hFF);
    send_byte(4'hA, 8'h00);
    // Switch coding in the middle of a field.
    send_bytes(KIND_LONG, 2, 128'h8182);
    drain();
    write_varint_enable(1'b0);
    finish_field();
    send_bytes(KIND_SHORT, 2, 128'h8000);
    send_bytes(KIND_UINT, 4, 128'hFFFF_FFFF);
    send_bytes(KIND_LONG, 8, 128'h8000_0000_0000_0001);
    send_bytes(KIND_TAG, 4, 128'h0000_01FF);
    send_bytes(KIND_STRING, 4, 128'h0000_0000);
    send_bytes(KIND_STRING, 4, 128'h0000_0001);
    send_byte(any_kind(), 8'h5A);
    send_bytes(KIND_INT, 2, 128'hABCD);
    drain();
    write_varint_enable(1'b1);
    finish_field();
    drain();

    while (items_used < ItemTarget) begin
      write_varint_enable(1'($urandom_range(0, 1)));
      tx_gaps = $urandom_range(0, 1);
      if (phase_no == 2) hold_req = 1'b1;
      target = items_used + $urandom_range(60, 200);
      while (items_used < target && items_used < ItemTarget) send_random_field();
      drain();
      phase_no++;
    end

    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
